FILE: hdl/gtrm_pkg.sv
// shared types and constants for the greedy tile rectangle merge block
package gtrm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_MASK = 2'd2;

  localparam int unsigned CFG_DATA_W = 64;

  typedef struct packed {
    logic [5:0] tile;
    logic       last_tile;
  } in_req_t;

  typedef struct packed {
    logic       found;
    logic [5:0] part;
    logic [2:0] row_start;
    logic [2:0] col_start;
    logic [2:0] row_end;
    logic [2:0] col_end;
    logic       last_rect;
  } out_req_t;

endpackage

FILE: hdl/greedy_tile_rectangle_merge.sv
// top level: tile loading, rectangle scan sequencer and result register
// Tiles load one per cycle while in_stall_o is low, into the grid store in
// row-major order. The request that carries last_tile starts a scan; during the
// scan no tile is taken. The sequencer reads one store entry per cycle through
// registered reads: a skipped cell (marked or empty) passes the read, check and
// advance steps, a non-merging cell the read, check, emit and advance steps, and
// a merging cell reads and tests each edge cell, sets the marks of each cell of
// an accepted edge, ends each growth round in a round step, then emits if it
// grew and advances. Each rectangle waits in a pending register until the next
// one or the end of the scan is known, then moves to the output register; the
// scan stalls in its emit step while both are full. At the end of the scan the
// final result is loaded once the output register is free, then a mark clearing
// pass over all MAX_ROWS*MAX_COLS entries (64 by default) follows; the same pass
// runs after reset.
module greedy_tile_rectangle_merge #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned TYPE_BITS = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [gtrm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  gtrm_pkg::in_req_t                  in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output gtrm_pkg::out_req_t                 out_req_o
);
  import gtrm_pkg::*;

  localparam int unsigned CELLS  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned POS_W  = $clog2(CELLS + 1);
  localparam int unsigned RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW    = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_LOAD, S_CELL_RD, S_CELL_CHK, S_COL_RD, S_COL_CHK, S_COL_MARK,
    S_ROW_RD, S_ROW_CHK, S_ROW_MARK, S_ROUND, S_EMIT, S_NEXT, S_DONE
  } state_e;

  // configuration registers
  logic [3:0]  row_cnt_q, col_cnt_q;
  logic [63:0] mask_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= 4'd8;
      col_cnt_q <= 4'd8;
      mask_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS: row_cnt_q <= cfg_data_i[3:0];
        CFG_COLS: col_cnt_q <= cfg_data_i[3:0];
        CFG_MASK: mask_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped grid dimensions
  logic [RCW-1:0] rows;
  logic [CCW-1:0] cols;
  always_comb begin
    if (row_cnt_q == 4'd0) rows = RCW'(1);
    else if (32'(row_cnt_q) > MAX_ROWS) rows = RCW'(MAX_ROWS);
    else rows = RCW'(row_cnt_q);
    if (col_cnt_q == 4'd0) cols = CCW'(1);
    else if (32'(col_cnt_q) > MAX_COLS) cols = CCW'(MAX_COLS);
    else cols = CCW'(col_cnt_q);
  end
  logic [POS_W-1:0] cells;
  assign cells = POS_W'(rows) * POS_W'(cols);

  state_e            state_q;
  logic [POS_W-1:0]  pos_q;
  logic [ADDR_W-1:0] clr_q;
  logic [RW-1:0]     r0_q, r_q, l_r_q;
  logic [CW-1:0]     c0_q, c_q, l_c_q;
  logic [5:0]        p_q;
  logic              g_q, grew_q;
  logic              pend_valid_q;
  out_req_t          pend_q;
  logic              out_valid_q;
  out_req_t          out_q;

  // store ports
  logic                 tile_we, mark_we, mark_wdata;
  logic [ADDR_W-1:0]    raddr, mwaddr;
  logic [5:0]           tile_rd;
  logic [TYPE_BITS-1:0] tile_rd_n;
  logic                 mark_rd;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c,
                                                  input logic [CCW-1:0] nc);
    logic [ADDR_W+CCW:0] a;
    a = (ADDR_W+CCW+1)'(r) * (ADDR_W+CCW+1)'(nc) + (ADDR_W+CCW+1)'(c);
    return a[ADDR_W-1:0];
  endfunction

  logic load_acc;
  assign in_stall_o = (state_q != S_LOAD);
  assign load_acc   = in_valid_i && (state_q == S_LOAD);
  assign tile_we    = load_acc && (pos_q < cells);

  // read address follows the sequencer phase
  always_comb begin
    case (state_q)
      S_COL_RD: raddr = cell_addr(l_r_q, CW'(c_q + 1'b1), cols);
      S_ROW_RD: raddr = cell_addr(RW'(r_q + 1'b1), l_c_q, cols);
      default:  raddr = cell_addr(r0_q, c0_q, cols);
    endcase
  end

  gtrm_store #(.CELLS(CELLS), .ADDR_W(ADDR_W), .TYPE_W(TYPE_BITS)) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tile_we_i    (tile_we),
    .tile_waddr_i (pos_q[ADDR_W-1:0]),
    .tile_wdata_i (in_req_i.tile[TYPE_BITS-1:0]),
    .tile_raddr_i (raddr),
    .tile_rdata_o (tile_rd_n),
    .mark_we_i    (mark_we),
    .mark_waddr_i (mwaddr),
    .mark_wdata_i (mark_wdata),
    .mark_raddr_i (raddr),
    .mark_rdata_o (mark_rd)
  );
  assign tile_rd = 6'(tile_rd_n);

  logic out_free, emit_go;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit_go  = !pend_valid_q || out_free;

  // mark writes: clearing pass, accepted edges, the start cell on emit
  always_comb begin
    mark_we    = 1'b0;
    mark_wdata = 1'b1;
    mwaddr     = cell_addr(r0_q, c0_q, cols);
    case (state_q)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_wdata = 1'b0;
        mwaddr     = clr_q;
      end
      S_COL_MARK: begin
        mark_we = 1'b1;
        mwaddr  = cell_addr(l_r_q, c_q, cols);
      end
      S_ROW_MARK: begin
        mark_we = 1'b1;
        mwaddr  = cell_addr(r_q, l_c_q, cols);
      end
      S_EMIT:  mark_we = emit_go;
      default: ;
    endcase
  end

  logic last_cell;
  assign last_cell = (32'(r0_q) + 1 == 32'(rows)) && (32'(c0_q) + 1 == 32'(cols));

  // rectangle built from the current growth
  out_req_t rect_d;
  always_comb begin
    rect_d           = '0;
    rect_d.found     = 1'b1;
    rect_d.part      = p_q;
    rect_d.row_start = 3'(r0_q);
    rect_d.col_start = 3'(c0_q);
    rect_d.row_end   = 3'(r_q);
    rect_d.col_end   = 3'(c_q);
  end

  // output register load: pending rectangle, or the final result
  logic     out_load;
  out_req_t out_d;
  always_comb begin
    out_load = 1'b0;
    out_d    = pend_q;
    case (state_q)
      S_EMIT: out_load = pend_valid_q && out_free;
      S_DONE: begin
        out_load = out_free;
        if (!pend_valid_q) out_d = '0;
        out_d.last_rect = 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_q       <= out_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // scan sequencer with pending rectangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      pos_q        <= '0;
      clr_q        <= '0;
      r0_q         <= '0;
      c0_q         <= '0;
      r_q          <= '0;
      c_q          <= '0;
      l_r_q        <= '0;
      l_c_q        <= '0;
      p_q          <= '0;
      g_q          <= 1'b0;
      grew_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (clr_q == ADDR_W'(CELLS - 1)) begin
            clr_q   <= '0;
            state_q <= S_LOAD;
          end else begin
            clr_q <= ADDR_W'(clr_q + 1'b1);
          end
        end
        S_LOAD: begin
          if (load_acc) begin
            if (tile_we) pos_q <= POS_W'(pos_q + 1'b1);
            if (in_req_i.last_tile) begin
              r0_q    <= '0;
              c0_q    <= '0;
              state_q <= S_CELL_RD;
            end
          end
        end
        S_CELL_RD: state_q <= S_CELL_CHK;
        S_CELL_CHK: begin
          p_q   <= tile_rd;
          r_q   <= r0_q;
          c_q   <= c0_q;
          g_q   <= 1'b0;
          l_r_q <= r0_q;
          l_c_q <= c0_q;
          if (mark_rd || tile_rd == 6'd0) begin
            grew_q  <= 1'b0;
            state_q <= S_NEXT;
          end else if (!mask_q[tile_rd]) begin
            grew_q  <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            grew_q <= 1'b0;
            if (32'(c0_q) + 1 < 32'(cols)) state_q <= S_COL_RD;
            else if (32'(r0_q) + 1 < 32'(rows)) state_q <= S_ROW_RD;
            else state_q <= S_ROUND;
          end
        end
        S_COL_RD: state_q <= S_COL_CHK;
        S_COL_CHK: begin
          if (tile_rd != p_q) begin
            // column fails; try the row
            l_c_q   <= c0_q;
            state_q <= (32'(r_q) + 1 < 32'(rows)) ? S_ROW_RD : S_ROUND;
          end else if (l_r_q == r_q) begin
            // whole column matches: widen, then mark it
            c_q     <= CW'(c_q + 1'b1);
            g_q     <= 1'b1;
            grew_q  <= 1'b1;
            l_r_q   <= r0_q;
            state_q <= S_COL_MARK;
          end else begin
            l_r_q   <= RW'(l_r_q + 1'b1);
            state_q <= S_COL_RD;
          end
        end
        S_COL_MARK: begin
          if (l_r_q == r_q) begin
            l_c_q   <= c0_q;
            state_q <= (32'(r_q) + 1 < 32'(rows)) ? S_ROW_RD : S_ROUND;
          end else begin
            l_r_q <= RW'(l_r_q + 1'b1);
          end
        end
        S_ROW_RD: state_q <= S_ROW_CHK;
        S_ROW_CHK: begin
          if (tile_rd != p_q) begin
            state_q <= S_ROUND;
          end else if (l_c_q == c_q) begin
            // whole row matches: extend, then mark it
            r_q     <= RW'(r_q + 1'b1);
            g_q     <= 1'b1;
            grew_q  <= 1'b1;
            l_c_q   <= c0_q;
            state_q <= S_ROW_MARK;
          end else begin
            l_c_q   <= CW'(l_c_q + 1'b1);
            state_q <= S_ROW_RD;
          end
        end
        S_ROW_MARK: begin
          if (l_c_q == c_q) begin
            state_q <= S_ROUND;
          end else begin
            l_c_q <= CW'(l_c_q + 1'b1);
          end
        end
        S_ROUND: begin
          g_q   <= 1'b0;
          l_r_q <= r0_q;
          l_c_q <= c0_q;
          if (!g_q) state_q <= grew_q ? S_EMIT : S_NEXT;
          else if (32'(c_q) + 1 < 32'(cols)) state_q <= S_COL_RD;
          else if (32'(r_q) + 1 < 32'(rows)) state_q <= S_ROW_RD;
          else state_q <= S_EMIT;
        end
        S_EMIT: begin
          // older rectangle moves out, this one waits as pending
          if (emit_go) begin
            pend_valid_q <= 1'b1;
            pend_q       <= rect_d;
            state_q      <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (last_cell) begin
            state_q <= S_DONE;
          end else begin
            if (32'(c0_q) + 1 == 32'(cols)) begin
              c0_q <= '0;
              r0_q <= RW'(r0_q + 1'b1);
            end else begin
              c0_q <= CW'(c0_q + 1'b1);
            end
            state_q <= S_CELL_RD;
          end
        end
        S_DONE: begin
          // final result leaves, then the marks are cleared
          if (out_free) begin
            pend_valid_q <= 1'b0;
            pos_q        <= '0;
            clr_q        <= '0;
            state_q      <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // assertions
  a_no_load_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_LOAD |-> in_stall_o) else $error("tile taken during scan");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cells) else $error("load position past grid");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

endmodule

FILE: hdl/gtrm_store.sv
// grid store: tile memory and confirmed-mark memory, registered reads
module gtrm_store #(
  parameter int unsigned CELLS  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned TYPE_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tile_we_i,
  input  logic [ADDR_W-1:0] tile_waddr_i,
  input  logic [TYPE_W-1:0] tile_wdata_i,
  input  logic [ADDR_W-1:0] tile_raddr_i,
  output logic [TYPE_W-1:0] tile_rdata_o,
  input  logic              mark_we_i,
  input  logic [ADDR_W-1:0] mark_waddr_i,
  input  logic              mark_wdata_i,
  input  logic [ADDR_W-1:0] mark_raddr_i,
  output logic              mark_rdata_o
);

  logic [TYPE_W-1:0] tile_mem [CELLS];
  logic              mark_mem [CELLS];

  // tile memory
  always_ff @(posedge clk_i) begin
    if (tile_we_i) begin
      tile_mem[tile_waddr_i] <= tile_wdata_i;
    end
    tile_rdata_o <= tile_mem[tile_raddr_i];
  end

  // mark memory, one entry written per cycle, cleared by a pass from the sequencer
  always_ff @(posedge clk_i) begin
    if (mark_we_i) begin
      mark_mem[mark_waddr_i] <= mark_wdata_i;
    end
  end

  // registered mark read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_rdata_o <= 1'b0;
    end else begin
      mark_rdata_o <= mark_mem[mark_raddr_i];
    end
  end

endmodule

FILE: dv/greedy_tile_rectangle_merge_tb.sv
// testbench for the greedy tile rectangle merge block
`timescale 1ns / 100ps

module greedy_tile_rectangle_merge_tb;
  import gtrm_pkg::*;

  localparam int unsigned GRID_ROWS = 8;
  localparam int unsigned GRID_COLS = 8;
  localparam int unsigned CELL_NUM = GRID_ROWS * GRID_COLS;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  in_req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  out_req_t out_req_o;

  greedy_tile_rectangle_merge dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o(out_req_o)
  );

  // shadow copy of block state
  logic [3:0] row_reg;
  logic [3:0] col_reg;
  logic [63:0] mask_reg;
  logic [5:0] grid_store [CELL_NUM] = '{default: '0};
  bit cell_done [CELL_NUM];
  int unsigned load_pos = 0;

  in_req_t tile_queue[$];
  out_req_t rect_queue[$];
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit hold_go;
  bit hold_seen = 0;
  int unsigned acc_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned item_cnt;

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(logic [3:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // stores the tile, and on last_tile greedy meshes the stored grid; one call per accepted request
  function automatic void merge_tiles(in_req_t req);
    int unsigned rows, cols, r0, c0, r, c, l, idx, n;
    logic [5:0] p;
    bit g1, g2, ok, grew;
    out_req_t res;
    rows = clamp_dim(row_reg, GRID_ROWS);
    cols = clamp_dim(col_reg, GRID_COLS);
    n = 0;
    if (load_pos < rows * cols) begin
      grid_store[load_pos] = req.tile;
      load_pos++;
    end
    if (!req.last_tile) return;
    foreach (cell_done[i]) cell_done[i] = 0;
    for (r0 = 0; r0 < rows; r0++) begin
      for (c0 = 0; c0 < cols; c0++) begin
        idx = r0 * cols + c0;
        p = grid_store[idx];
        if (cell_done[idx] || p == 0) continue;
        r = r0;
        c = c0;
        grew = 0;
        if (mask_reg[p]) begin
          do begin
            g1 = 0;
            g2 = 0;
            // try one column to the right
            if (c + 1 < cols) begin
              ok = 1;
              for (l = r0; l <= r; l++) if (grid_store[l * cols + c + 1] != p) ok = 0;
              if (ok) begin
                c++;
                for (l = r0; l <= r; l++) cell_done[l * cols + c] = 1;
                g1 = 1;
              end
            end
            // try one row below
            if (r + 1 < rows) begin
              ok = 1;
              for (l = c0; l <= c; l++) if (grid_store[(r + 1) * cols + l] != p) ok = 0;
              if (ok) begin
                r++;
                for (l = c0; l <= c; l++) cell_done[r * cols + l] = 1;
                g2 = 1;
              end
            end
            grew |= g1 | g2;
          end while (g1 || g2);
          if (!grew) continue;
        end
        cell_done[idx] = 1;
        res = '0;
        res.found = 1'b1;
        res.part = p;
        res.row_start = r0[2:0];
        res.col_start = c0[2:0];
        res.row_end = r[2:0];
        res.col_end = c[2:0];
        rect_queue = {rect_queue, res};
        n++;
      end
    end
    // a grid with no rectangles gives a single blank result
    if (n == 0) begin
      res = '0;
      rect_queue = {rect_queue, res};
    end
    rect_queue[rect_queue.size() - 1].last_rect = 1'b1;
    load_pos = 0;
    foreach (cell_done[i]) cell_done[i] = 0;
  endfunction

  // input acceptance and output check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        merge_tiles(in_req_i);
        acc_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (rect_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_req_o);
          mismatch_cnt++;
        end else begin
          if (out_req_o !== rect_queue[0]) begin
            $display("%0t: result differs, expected %p, actual %p",
                     $time, rect_queue[0], out_req_o);
            mismatch_cnt++;
          end
          void'(rect_queue.pop_front());
        end
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else if (!in_valid_i || acc_cnt == sent_cnt) begin
      if (tile_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i <= tile_queue.pop_front();
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_cnt = HOLD_CYCLES;
      hold_seen = 1;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end
    out_stall_i <= rst_ni && (hold_cnt != 0 || $urandom_range(99) < stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] index, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    case (index)
      CFG_ROWS: row_reg = value[3:0];
      CFG_COLS: col_reg = value[3:0];
      CFG_MASK: mask_reg = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tile_queue.size() != 0 || in_valid_i || rect_queue.size() != 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic push_tile(int unsigned t, bit last);
    in_req_t req;
    req.tile = t[5:0];
    req.last_tile = last;
    tile_queue = {tile_queue, req};
    item_cnt++;
  endtask

  // one grid: kind 0 patterned, 1 fully random, 2 short, 3 overfull
  task automatic queue_grid(int unsigned kind);
    int unsigned cells, n, r, c, cols;
    logic [5:0] pal [3];
    logic [5:0] t;
    cols = clamp_dim(col_reg, GRID_COLS);
    cells = clamp_dim(row_reg, GRID_ROWS) * cols;
    n = cells;
    if (kind == 2) n = $urandom_range(1, cells);
    if (kind == 3) n = cells + $urandom_range(1, 6);
    foreach (pal[i]) pal[i] = 6'($urandom_range(63));
    if ($urandom_range(3) == 0) pal[2] = 0;
    for (int unsigned i = 0; i < n; i++) begin
      r = (i % cells) / cols;
      c = (i % cells) % cols;
      if (kind == 1) t = 6'($urandom_range(63));
      else if ($urandom_range(99) < 15) t = pal[$urandom_range(2)];
      else t = pal[((r / 3) + (c / 3)) % 3];
      push_tile(t, i == n - 1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ROWS;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 0;
    item_cnt = 0;
    row_reg = 4'd8;
    col_reg = 4'd8;
    mask_reg = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full grid of single cells fills every store entry, extremes included
    for (int unsigned i = 0; i < CELL_NUM; i++)
      push_tile((i % 4 == 0) ? 0 : (i % 4 == 1) ? 63 : i, i == CELL_NUM - 1);
    wait_idle();
    // single cell grids: empty cell, and a merging cell that cannot grow
    write_reg(CFG_MASK, '1);
    write_reg(CFG_ROWS, 1);
    write_reg(CFG_COLS, 1);
    push_tile(0, 1);
    push_tile(63, 1);
    wait_idle();
    // a 2x2 block merges, then a short grid, then an overfull one
    write_reg(CFG_ROWS, 2);
    write_reg(CFG_COLS, 2);
    for (int i = 0; i < 4; i++) push_tile(5, i == 3);
    push_tile(7, 1);
    for (int i = 0; i < 6; i++) push_tile(9, i == 5);
    wait_idle();
    // out of range sizes saturate
    write_reg(CFG_ROWS, 0);
    write_reg(CFG_COLS, 15);
    for (int i = 0; i < 8; i++) push_tile(i < 4 ? 42 : 21, i == 7);
    wait_idle();

    // random phases over sizes, masks and idling mixes
    for (int unsigned ph = 0; ph < 8; ph++) begin
      int unsigned target;
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      case (ph % 5)
        0: write_reg(CFG_ROWS, 8);
        1: write_reg(CFG_ROWS, 1);
        2: write_reg(CFG_ROWS, {$urandom, $urandom});
        3: write_reg(CFG_ROWS, 15);
        default: write_reg(CFG_ROWS, $urandom_range(1, 8));
      endcase
      case (ph % 3)
        0: write_reg(CFG_COLS, 8);
        1: write_reg(CFG_COLS, $urandom_range(0, 15));
        default: write_reg(CFG_COLS, 1);
      endcase
      case (ph % 4)
        0: write_reg(CFG_MASK, '1);
        1: write_reg(CFG_MASK, '0);
        default: write_reg(CFG_MASK, {$urandom, $urandom});
      endcase
      if (ph == 5) hold_go = 1;
      target = item_cnt + 48;
      while (item_cnt < target) begin
        int unsigned pick;
        pick = $urandom_range(9);
        queue_grid(pick < 6 ? 0 : pick - 6);
      end
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/gtrm_pkg.sv
hdl/gtrm_store.sv
hdl/greedy_tile_rectangle_merge.sv
dv/greedy_tile_rectangle_merge_tb.sv
